// File: rtl/tahr_pkg.sv
// tahr_pkg: shared types and constants for the temperature alarm relay core
`timescale 1ns / 1ps

package tahr_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ALERT_METHOD  = 3'd0,
    CFG_LEVEL_ZERO    = 3'd1,
    CFG_LEVEL_ONE     = 3'd2,
    CFG_DIFF_LEVEL    = 3'd3,
    CFG_HYST_BAND     = 3'd4,
    CFG_IMPULSE_LEN   = 3'd5,
    CFG_SECOND_DELAY  = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    METHOD_PER_SENSOR = 1'b0,
    METHOD_DIFFERENCE = 1'b1
  } alert_method_e;

  typedef enum logic {
    CMD_CHECK = 1'b0,
    CMD_TICK  = 1'b1
  } command_e;

  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 24;
  localparam int unsigned TempWidth = 12;
  localparam int unsigned BandWidth = 10;
  localparam int unsigned ImpulseWidth = 16;
  localparam int unsigned DelayWidth = 24;
  // sums of a level and the band fit here with margin
  localparam int unsigned CmpWidth = 14;

  localparam logic [DelayWidth-1:0] DelayMax = {DelayWidth{1'b1}};

  localparam logic [TempWidth-1:0]    LevelReset     = 12'd480;
  localparam logic [TempWidth-1:0]    DiffLevelReset = 12'd160;
  localparam logic [BandWidth-1:0]    BandReset      = 10'd8;
  localparam logic [ImpulseWidth-1:0] ImpulseReset   = 16'd1000;

  typedef struct packed {
    alert_method_e            method;
    logic [TempWidth-1:0]     level_zero;
    logic [TempWidth-1:0]     level_one;
    logic [TempWidth-1:0]     diff_level;
    logic [BandWidth-1:0]     band;
    logic [ImpulseWidth-1:0]  impulse_len;
    logic [DelayWidth-1:0]    second_delay;
  } cfg_t;

  typedef struct packed {
    command_e              command;
    logic [TempWidth-1:0]  temp_zero;
    logic [TempWidth-1:0]  temp_one;
    logic [1:0]            sensor_count;
    logic                  fault_zero;
    logic                  fault_one;
    logic                  alarm_disable;
    logic                  impulse_mode;
  } item_t;

  typedef struct packed {
    logic alert;
    logic alert_changed;
    logic relay_on;
  } result_t;

endpackage

// File: rtl/tahr_cfg_regs.sv
// tahr_cfg_regs: configuration register file written through the config channel
`timescale 1ns / 1ps

module tahr_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [tahr_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [tahr_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output tahr_pkg::cfg_t                       cfg_o
);

  tahr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (tahr_pkg::cfg_idx_e'(cfg_index_i))
        tahr_pkg::CFG_ALERT_METHOD:
          cfg_d.method = tahr_pkg::alert_method_e'(cfg_data_i[0]);
        tahr_pkg::CFG_LEVEL_ZERO:   cfg_d.level_zero = cfg_data_i[tahr_pkg::TempWidth-1:0];
        tahr_pkg::CFG_LEVEL_ONE:    cfg_d.level_one = cfg_data_i[tahr_pkg::TempWidth-1:0];
        tahr_pkg::CFG_DIFF_LEVEL:   cfg_d.diff_level = cfg_data_i[tahr_pkg::TempWidth-1:0];
        tahr_pkg::CFG_HYST_BAND:    cfg_d.band = cfg_data_i[tahr_pkg::BandWidth-1:0];
        tahr_pkg::CFG_IMPULSE_LEN:
          cfg_d.impulse_len = cfg_data_i[tahr_pkg::ImpulseWidth-1:0];
        tahr_pkg::CFG_SECOND_DELAY:
          cfg_d.second_delay = cfg_data_i[tahr_pkg::DelayWidth-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.method       <= tahr_pkg::METHOD_PER_SENSOR;
      cfg_q.level_zero   <= tahr_pkg::LevelReset;
      cfg_q.level_one    <= tahr_pkg::LevelReset;
      cfg_q.diff_level   <= tahr_pkg::DiffLevelReset;
      cfg_q.band         <= tahr_pkg::BandReset;
      cfg_q.impulse_len  <= tahr_pkg::ImpulseReset;
      cfg_q.second_delay <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/tahr_alert_eval.sv
// tahr_alert_eval: hysteresis decision for one check transaction
`timescale 1ns / 1ps

module tahr_alert_eval (
  input  tahr_pkg::cfg_t   cfg_i,
  input  tahr_pkg::item_t  item_i,
  input  logic             alert_i,
  output logic             alert_next_o
);

  localparam int unsigned W = tahr_pkg::CmpWidth;

  logic signed [W-1:0] t0, t1, lvl0, lvl1, dlvl, band;
  logic signed [W-1:0] set0, clr0, set1, clr1, dset, dclr;
  logic signed [W-1:0] diff, diff_abs;
  logic                use0, use1, any_above, all_below, diff_ok;

  always_comb begin
    t0   = W'($signed(item_i.temp_zero));
    t1   = W'($signed(item_i.temp_one));
    lvl0 = W'($signed(cfg_i.level_zero));
    lvl1 = W'($signed(cfg_i.level_one));
    dlvl = $signed({{(W-tahr_pkg::TempWidth){1'b0}}, cfg_i.diff_level});
    band = $signed({{(W-tahr_pkg::BandWidth){1'b0}}, cfg_i.band});

    set0 = lvl0 + band;
    clr0 = lvl0 - band;
    set1 = lvl1 + band;
    clr1 = lvl1 - band;
    dset = dlvl + band;
    dclr = dlvl - band;

    // a count of three behaves as two
    use0 = (item_i.sensor_count != 2'd0) && !item_i.fault_zero;
    use1 = item_i.sensor_count[1] && !item_i.fault_one;

    any_above = (use0 && (t0 >= set0)) || (use1 && (t1 >= set1));
    all_below = !(use0 && (t0 >= clr0)) && !(use1 && (t1 >= clr1));

    diff     = t1 - t0;
    diff_abs = diff[W-1] ? -diff : diff;
    diff_ok  = item_i.sensor_count[1] && !item_i.fault_zero && !item_i.fault_one;

    alert_next_o = alert_i;
    if (item_i.alarm_disable) begin
      alert_next_o = 1'b0;
    end else if (cfg_i.method == tahr_pkg::METHOD_PER_SENSOR) begin
      if (any_above) begin
        alert_next_o = 1'b1;
      end else if (all_below) begin
        alert_next_o = 1'b0;
      end
    end else if (diff_ok) begin
      if (diff_abs >= dset) begin
        alert_next_o = 1'b1;
      end else if (diff_abs <= dclr) begin
        alert_next_o = 1'b0;
      end
    end
  end

endmodule

// File: rtl/tahr_relay_ctrl.sv
// tahr_relay_ctrl: alert flag, relay level and impulse timers
`timescale 1ns / 1ps

module tahr_relay_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  tahr_pkg::cfg_t    cfg_i,
  input  tahr_pkg::item_t   item_i,
  input  logic              alert_next_i,
  output logic              alert_o,
  output tahr_pkg::result_t result_o
);

  logic                                alert_q, alert_d;
  logic                                relay_q, relay_d;
  logic [tahr_pkg::ImpulseWidth-1:0]   imp_q, imp_d, imp_len;
  logic [tahr_pkg::DelayWidth-1:0]     sec_q, sec_d, sec_load;
  logic                                changed;

  always_comb begin
    imp_len  = (cfg_i.impulse_len == '0) ? tahr_pkg::ImpulseWidth'(1) : cfg_i.impulse_len;
    sec_load = (cfg_i.second_delay == tahr_pkg::DelayMax) ? tahr_pkg::DelayMax
                                                           : cfg_i.second_delay + 1'b1;
    alert_d = alert_q;
    relay_d = relay_q;
    imp_d   = imp_q;
    sec_d   = sec_q;
    changed = 1'b0;

    if (item_i.command == tahr_pkg::CMD_TICK) begin
      if (imp_q != '0) begin
        imp_d = imp_q - 1'b1;
        if (imp_q == tahr_pkg::ImpulseWidth'(1)) begin
          relay_d = 1'b0;
        end
      end
      if (sec_q != '0) begin
        sec_d = sec_q - 1'b1;
        if (sec_q == tahr_pkg::DelayWidth'(1)) begin
          relay_d = 1'b1;
          imp_d   = imp_len;
        end
      end
    end else if (alert_next_i != alert_q) begin
      alert_d = alert_next_i;
      changed = 1'b1;
      if (item_i.impulse_mode) begin
        relay_d = 1'b1;
        imp_d   = imp_len;
        if (alert_next_i && (cfg_i.second_delay != '0)) begin
          sec_d = sec_load;
        end
      end else begin
        relay_d = alert_next_i;
        imp_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alert_q <= 1'b0;
      relay_q <= 1'b0;
      imp_q   <= '0;
      sec_q   <= '0;
    end else if (step_i) begin
      alert_q <= alert_d;
      relay_q <= relay_d;
      imp_q   <= imp_d;
      sec_q   <= sec_d;
    end
  end

  assign alert_o                = alert_q;
  assign result_o.alert         = alert_d;
  assign result_o.alert_changed = changed;
  assign result_o.relay_on      = relay_d;

endmodule

// File: rtl/temperature_alarm_hysteresis_relay_core.sv
// temperature_alarm_hysteresis_relay_core: top level of the hysteresis alarm relay
`timescale 1ns / 1ps

// channel   direction  handshake                   payload
// input     in         in_valid_i / in_stall_o     command, temps, count, faults, jumpers
// output    out        out_valid_o / out_stall_i   alert, alert_changed, relay_on
// config    in         cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// one transaction per cycle sustained while the output is not stalled; a result
// passes through the input register, then the result register
// rst_ni clears the config to its defaults, the alert, relay and both timers
// a stalled output holds its result; the input register still drains into the
// result register as soon as the consumer takes the waiting transaction

module temperature_alarm_hysteresis_relay_core (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // input channel
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic                                     command_i,
  input  logic signed [tahr_pkg::TempWidth-1:0]    temp_zero_i,
  input  logic signed [tahr_pkg::TempWidth-1:0]    temp_one_i,
  input  logic [1:0]                               sensor_count_i,
  input  logic                                     fault_zero_i,
  input  logic                                     fault_one_i,
  input  logic                                     alarm_disable_i,
  input  logic                                     impulse_mode_i,
  // output channel
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic                                     alert_o,
  output logic                                     alert_changed_o,
  output logic                                     relay_on_o,
  // configuration write channel
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [tahr_pkg::CfgIdxWidth-1:0]         cfg_index_i,
  input  logic [tahr_pkg::CfgDataWidth-1:0]        cfg_data_i
);

  tahr_pkg::cfg_t    cfg;
  tahr_pkg::item_t   item_q, item_d;
  tahr_pkg::result_t res_q, res_next;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              step;      // input register hands its transaction on
  logic              in_take;
  logic              alert_cur;
  logic              alert_next;

  // config is always taken; writes are only expected while the block is idle
  assign cfg_ready_o = 1'b1;

  tahr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // result register free, or being emptied this cycle
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    item_d.command       = tahr_pkg::command_e'(command_i);
    item_d.temp_zero     = temp_zero_i;
    item_d.temp_one      = temp_one_i;
    item_d.sensor_count  = sensor_count_i;
    item_d.fault_zero    = fault_zero_i;
    item_d.fault_one     = fault_one_i;
    item_d.alarm_disable = alarm_disable_i;
    item_d.impulse_mode  = impulse_mode_i;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
  end

  // hysteresis decision against the current alert
  tahr_alert_eval u_eval (
    .cfg_i        (cfg),
    .item_i       (item_q),
    .alert_i      (alert_cur),
    .alert_next_o (alert_next)
  );

  // alert flag, relay and the millisecond timers update on each step
  tahr_relay_ctrl u_relay (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .cfg_i        (cfg),
    .item_i       (item_q),
    .alert_next_i (alert_next),
    .alert_o      (alert_cur),
    .result_o     (res_next)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign alert_o         = res_q.alert;
  assign alert_changed_o = res_q.alert_changed;
  assign relay_on_o      = res_q.relay_on;

endmodule

// File: bench/temperature_alarm_hysteresis_relay_core_test.sv
// self-checking test of the hysteresis alarm relay core against a tracking model
`timescale 1ns / 1ps

class alarm_relay_tracker;
  tahr_pkg::alert_method_e                method;
  logic signed [tahr_pkg::TempWidth-1:0]  level_zero;
  logic signed [tahr_pkg::TempWidth-1:0]  level_one;
  logic [tahr_pkg::TempWidth-1:0]         diff_level;
  logic [tahr_pkg::BandWidth-1:0]         band;
  logic [tahr_pkg::ImpulseWidth-1:0]      impulse_len;
  logic [tahr_pkg::DelayWidth-1:0]        second_delay;
  bit                                     alert_flag;
  bit                                     relay_level;
  bit [tahr_pkg::ImpulseWidth-1:0]        impulse_left;
  bit [tahr_pkg::DelayWidth-1:0]          second_left;
  tahr_pkg::result_t                      awaited_outputs[$];
  int unsigned                            errors;

  function void power_up();
    method       = tahr_pkg::METHOD_PER_SENSOR;
    level_zero   = tahr_pkg::LevelReset;
    level_one    = tahr_pkg::LevelReset;
    diff_level   = tahr_pkg::DiffLevelReset;
    band         = tahr_pkg::BandReset;
    impulse_len  = tahr_pkg::ImpulseReset;
    second_delay = '0;
    alert_flag   = 1'b0;
    relay_level  = 1'b0;
    impulse_left = '0;
    second_left  = '0;
    errors       = 0;
    awaited_outputs.delete();
  endfunction

  function void write_reg(tahr_pkg::cfg_idx_e idx, logic [tahr_pkg::CfgDataWidth-1:0] data);
    case (idx)
      tahr_pkg::CFG_ALERT_METHOD: method = tahr_pkg::alert_method_e'(data[0]);
      tahr_pkg::CFG_LEVEL_ZERO:   level_zero   = data[tahr_pkg::TempWidth-1:0];
      tahr_pkg::CFG_LEVEL_ONE:    level_one    = data[tahr_pkg::TempWidth-1:0];
      tahr_pkg::CFG_DIFF_LEVEL:   diff_level   = data[tahr_pkg::TempWidth-1:0];
      tahr_pkg::CFG_HYST_BAND:    band         = data[tahr_pkg::BandWidth-1:0];
      tahr_pkg::CFG_IMPULSE_LEN:  impulse_len  = data[tahr_pkg::ImpulseWidth-1:0];
      tahr_pkg::CFG_SECOND_DELAY: second_delay = data[tahr_pkg::DelayWidth-1:0];
      default: ;
    endcase
  endfunction

  function void start_impulse();
    relay_level  = 1'b1;
    impulse_left = (impulse_len != 0) ? impulse_len : tahr_pkg::ImpulseWidth'(1);
  endfunction

  // moves the alarm state on by one transaction and queues what it shows
  function void advance_alarm(tahr_pkg::item_t it);
    int                t[2];
    int                lvl[2];
    bit                flt[2];
    int                count;
    int                bw;
    int                d;
    bit                alert_next;
    bit                any_above;
    bit                all_below;
    tahr_pkg::result_t r;
    r = '0;
    if (it.command == tahr_pkg::CMD_TICK) begin
      if (impulse_left != 0) begin
        impulse_left--;
        if (impulse_left == 0) relay_level = 1'b0;
      end
      if (second_left != 0) begin
        second_left--;
        if (second_left == 0) start_impulse();
      end
    end else begin
      t[0]   = int'($signed(it.temp_zero));
      t[1]   = int'($signed(it.temp_one));
      lvl[0] = int'(level_zero);
      lvl[1] = int'(level_one);
      flt[0] = it.fault_zero;
      flt[1] = it.fault_one;
      bw     = int'(band);
      count  = (it.sensor_count > 2) ? 2 : int'(it.sensor_count);
      alert_next = alert_flag;
      if (it.alarm_disable) begin
        alert_next = 1'b0;
      end else if (method == tahr_pkg::METHOD_PER_SENSOR) begin
        any_above = 1'b0;
        all_below = 1'b1;
        for (int i = 0; i < count; i++) begin
          if (flt[i]) continue;
          if (t[i] >= lvl[i] + bw) any_above = 1'b1;
          if (t[i] >= lvl[i] - bw) all_below = 1'b0;
        end
        if (any_above) alert_next = 1'b1;
        else if (all_below) alert_next = 1'b0;
      end else if (count == 2 && !flt[0] && !flt[1]) begin
        d = t[1] - t[0];
        if (d < 0) d = -d;
        if (d >= int'(diff_level) + bw) alert_next = 1'b1;
        else if (d <= int'(diff_level) - bw) alert_next = 1'b0;
      end
      if (alert_next != alert_flag) begin
        alert_flag      = alert_next;
        r.alert_changed = 1'b1;
        if (it.impulse_mode) begin
          start_impulse();
          if (alert_flag && second_delay != 0)
            second_left = (second_delay == tahr_pkg::DelayMax) ? tahr_pkg::DelayMax
                                                                : second_delay + 1'b1;
        end else begin
          relay_level  = alert_flag;
          impulse_left = '0;
        end
      end
    end
    r.alert    = alert_flag;
    r.relay_on = relay_level;
    awaited_outputs.push_back(r);
  endfunction

  function void check_result(tahr_pkg::result_t got);
    tahr_pkg::result_t want;
    if (awaited_outputs.size() == 0) begin
      $display("%0t: result alert %0b changed %0b relay %0b with nothing awaited",
               $time, got.alert, got.alert_changed, got.relay_on);
      errors++;
      return;
    end
    want = awaited_outputs.pop_front();
    if (got.alert !== want.alert) begin
      $display("%0t: alert expected %0b actual %0b", $time, want.alert, got.alert);
      errors++;
    end
    if (got.alert_changed !== want.alert_changed) begin
      $display("%0t: alert_changed expected %0b actual %0b",
               $time, want.alert_changed, got.alert_changed);
      errors++;
    end
    if (got.relay_on !== want.relay_on) begin
      $display("%0t: relay_on expected %0b actual %0b", $time, want.relay_on, got.relay_on);
      errors++;
    end
  endfunction
endclass

module temperature_alarm_hysteresis_relay_core_test;

  localparam int ClkHalf      = 6;
  localparam int ResetCycles  = 12;
  localparam int LimitCycles  = 200000;
  localparam int HoldCycles   = 80;
  localparam int TailCycles   = 8;
  localparam int PhaseItems   = 125;
  localparam int RandomPhases = 6;

  // every input starts at a known level
  logic                                   clk_i           = 1'b0;
  logic                                   rst_ni          = 1'b0;
  logic                                   in_valid_i      = 1'b0;
  logic                                   in_stall_o;
  logic                                   command_i       = 1'b0;
  logic signed [tahr_pkg::TempWidth-1:0]  temp_zero_i     = '0;
  logic signed [tahr_pkg::TempWidth-1:0]  temp_one_i      = '0;
  logic [1:0]                             sensor_count_i  = '0;
  logic                                   fault_zero_i    = 1'b0;
  logic                                   fault_one_i     = 1'b0;
  logic                                   alarm_disable_i = 1'b0;
  logic                                   impulse_mode_i  = 1'b0;
  logic                                   out_valid_o;
  logic                                   out_stall_i     = 1'b0;
  logic                                   alert_o;
  logic                                   alert_changed_o;
  logic                                   relay_on_o;
  logic                                   cfg_valid_i     = 1'b0;
  logic                                   cfg_ready_o;
  logic [tahr_pkg::CfgIdxWidth-1:0]       cfg_index_i     = '0;
  logic [tahr_pkg::CfgDataWidth-1:0]      cfg_data_i      = '0;

  alarm_relay_tracker tracker = new;

  // idling rates of the two sides, in percent
  int          idle_pct = 20;
  int          stall_pct = 20;
  // long receiver hold-offs are asked for by bumping this count
  int unsigned hold_requests = 0;
  int unsigned rx_holds_seen = 0;
  int unsigned rx_hold_left = 0;

  temperature_alarm_hysteresis_relay_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .temp_zero_i     (temp_zero_i),
    .temp_one_i      (temp_one_i),
    .sensor_count_i  (sensor_count_i),
    .fault_zero_i    (fault_zero_i),
    .fault_one_i     (fault_one_i),
    .alarm_disable_i (alarm_disable_i),
    .impulse_mode_i  (impulse_mode_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .alert_o         (alert_o),
    .alert_changed_o (alert_changed_o),
    .relay_on_o      (relay_on_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // hard stop in case the block hangs
  initial begin
    #(LimitCycles * 2 * ClkHalf);
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: check each transaction taken, then pick next cycle's stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_result('{alert: alert_o, alert_changed: alert_changed_o,
                             relay_on: relay_on_o});
    if (rx_hold_left != 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_holds_seen != hold_requests) begin
      // long hold-off so the block backs up into the input channel
      rx_holds_seen = hold_requests;
      rx_hold_left  = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (int'($urandom_range(99)) < stall_pct);
    end
  end

  function automatic logic [tahr_pkg::TempWidth-1:0] clamp12(int v);
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v[tahr_pkg::TempWidth-1:0];
  endfunction

  // a value just around centre or one of the two band edges
  function automatic int near_edge(int centre, int bw);
    int r;
    r = $urandom_range(2);
    if (r == 0) centre -= bw;
    else if (r == 1) centre += bw;
    return centre + int'($urandom_range(4)) - 2;
  endfunction

  function automatic tahr_pkg::item_t check_item(int t0, int t1, int cnt, bit f0, bit f1,
                                                 bit dis, bit imp);
    tahr_pkg::item_t it;
    it               = '0;
    it.command       = tahr_pkg::CMD_CHECK;
    it.temp_zero     = clamp12(t0);
    it.temp_one      = clamp12(t1);
    it.sensor_count  = cnt[1:0];
    it.fault_zero    = f0;
    it.fault_one     = f1;
    it.alarm_disable = dis;
    it.impulse_mode  = imp;
    return it;
  endfunction

  // tick with junk in the unused fields
  function automatic tahr_pkg::item_t tick_item();
    logic [31:0]     raw;
    tahr_pkg::item_t it;
    raw        = $urandom;
    it         = raw[$bits(tahr_pkg::item_t)-1:0];
    it.command = tahr_pkg::CMD_TICK;
    return it;
  endfunction

  // mostly checks that sit on the switching edges of the current setup
  function automatic tahr_pkg::item_t random_item();
    tahr_pkg::item_t it;
    int              c0;
    int              gap;
    int              r;
    it = tick_item();
    if ($urandom_range(99) < 35) return it;
    it.command = tahr_pkg::CMD_CHECK;
    r = $urandom_range(9);
    it.sensor_count  = (r == 0) ? 2'd0 : (r == 1) ? 2'd1 : (r == 2) ? 2'd3 : 2'd2;
    it.fault_zero    = ($urandom_range(9) == 0);
    it.fault_one     = ($urandom_range(9) == 0);
    it.alarm_disable = ($urandom_range(19) == 0);
    it.impulse_mode  = 1'($urandom_range(1));
    // keep the raw temperatures now and then
    if ($urandom_range(4) == 0) return it;
    if (tracker.method == tahr_pkg::METHOD_PER_SENSOR) begin
      it.temp_zero = clamp12(near_edge(int'(tracker.level_zero), int'(tracker.band)));
      it.temp_one  = clamp12(near_edge(int'(tracker.level_one), int'(tracker.band)));
    end else begin
      c0  = int'($urandom_range(600)) - 300;
      gap = near_edge(int'(tracker.diff_level), int'(tracker.band));
      if ($urandom_range(1)) gap = -gap;
      it.temp_zero = clamp12(c0);
      it.temp_one  = clamp12(c0 + gap);
    end
    return it;
  endfunction

  // small band, short impulses and delays so the timers run out often
  function automatic tahr_pkg::cfg_t random_config();
    tahr_pkg::cfg_t c;
    c.method     = tahr_pkg::alert_method_e'($urandom_range(1));
    c.level_zero = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 12'h7FF : 12'h800)
                                            : clamp12(int'($urandom_range(1200)) - 400);
    c.level_one  = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 12'h7FF : 12'h800)
                                            : clamp12(int'($urandom_range(1200)) - 400);
    c.diff_level = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 12'hFFF : 12'h000)
                                            : 12'($urandom_range(300));
    c.band       = ($urandom_range(7) == 0) ? 10'h3FF : 10'($urandom_range(24));
    case ($urandom_range(15))
      0:       c.impulse_len = 16'h0000;
      1:       c.impulse_len = 16'hFFFF;
      default: c.impulse_len = 16'($urandom_range(1, 12));
    endcase
    c.second_delay = $urandom_range(1) ? 24'($urandom_range(1, 30)) : 24'h0;
    return c;
  endfunction

  // offer one transaction and hold it until taken; valid stays up for the next unless an idle gap is drawn
  task automatic send_item(tahr_pkg::item_t it);
    in_valid_i      <= 1'b1;
    command_i       <= it.command;
    temp_zero_i     <= it.temp_zero;
    temp_one_i      <= it.temp_one;
    sensor_count_i  <= it.sensor_count;
    fault_zero_i    <= it.fault_zero;
    fault_one_i     <= it.fault_one;
    alarm_disable_i <= it.alarm_disable;
    impulse_mode_i  <= it.impulse_mode;
    do @(posedge clk_i); while (in_stall_o);
    tracker.advance_alarm(it);
    if (int'($urandom_range(99)) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // stop sending and wait for every awaited result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.awaited_outputs.size() != 0) @(posedge clk_i);
  endtask

  // one register write; valid is left up for a following write
  task automatic put_reg(tahr_pkg::cfg_idx_e idx, logic [tahr_pkg::CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
  endtask

  task automatic apply_config(tahr_pkg::cfg_t c);
    put_reg(tahr_pkg::CFG_ALERT_METHOD, 24'(c.method));
    put_reg(tahr_pkg::CFG_LEVEL_ZERO,   24'(c.level_zero));
    put_reg(tahr_pkg::CFG_LEVEL_ONE,    24'(c.level_one));
    put_reg(tahr_pkg::CFG_DIFF_LEVEL,   24'(c.diff_level));
    put_reg(tahr_pkg::CFG_HYST_BAND,    24'(c.band));
    put_reg(tahr_pkg::CFG_IMPULSE_LEN,  24'(c.impulse_len));
    put_reg(tahr_pkg::CFG_SECOND_DELAY, 24'(c.second_delay));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    tahr_pkg::cfg_t cfg;
    tracker.power_up();
    cfg.method       = tahr_pkg::METHOD_PER_SENSOR;
    cfg.level_zero   = tahr_pkg::LevelReset;
    cfg.level_one    = tahr_pkg::LevelReset;
    cfg.diff_level   = tahr_pkg::DiffLevelReset;
    cfg.band         = tahr_pkg::BandReset;
    cfg.impulse_len  = tahr_pkg::ImpulseReset;
    cfg.second_delay = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default setup: per-sensor threshold 480, band 8
    send_item(check_item(2047, -2048, 2, 0, 0, 0, 0));  // rise, relay follows
    send_item(check_item(476, 0, 1, 0, 0, 0, 0));       // inside the band, kept
    send_item(check_item(-2048, -2048, 3, 0, 0, 0, 0)); // count above two, clears
    send_item(check_item(488, 0, 1, 0, 0, 0, 1));       // rise into an impulse
    send_item(tick_item());
    send_item(tick_item());
    send_item(check_item(2047, 2047, 0, 0, 0, 0, 1));   // no sensors, so all below
    send_item(check_item(0, 2047, 2, 1, 0, 0, 0));      // faulty sensor skipped
    send_item(check_item(2047, 2047, 2, 0, 0, 1, 1));   // disabled, clears
    send_item(check_item(2047, 2047, 2, 1, 1, 0, 0));   // both faulty, none usable
    send_item(tick_item());

    // difference mode, band wider than the level, zero length impulse
    drain();
    cfg.method       = tahr_pkg::METHOD_DIFFERENCE;
    cfg.diff_level   = 12'd4;
    cfg.band         = 10'h3FF;
    cfg.impulse_len  = 16'h0000;
    cfg.second_delay = 24'd2;
    apply_config(cfg);
    send_item(check_item(-2048, 2047, 2, 0, 0, 0, 1));  // widest gap, second scheduled
    send_item(tick_item());
    send_item(check_item(0, 0, 2, 0, 0, 0, 0));         // never clears by difference
    send_item(check_item(-2048, 2047, 1, 0, 0, 0, 0));  // one sensor, kept
    send_item(check_item(-2048, 2047, 2, 0, 1, 0, 0));  // faulty sensor, kept
    send_item(tick_item());
    send_item(tick_item());                             // second impulse fires here
    send_item(check_item(0, 0, 2, 0, 0, 1, 0));         // disabled in difference mode

    // extreme levels, zero band, longest impulse, saturating delay
    drain();
    cfg.level_zero   = 12'h800;
    cfg.level_one    = 12'h7FF;
    cfg.diff_level   = 12'hFFF;
    cfg.band         = 10'h000;
    cfg.impulse_len  = 16'hFFFF;
    cfg.second_delay = tahr_pkg::DelayMax;
    apply_config(cfg);
    send_item(check_item(-2048, 2047, 2, 0, 0, 0, 1));
    send_item(tick_item());
    send_item(check_item(5, 5, 2, 0, 0, 0, 0));         // level edge cancels the impulse
    send_item(tick_item());
    drain();
    cfg.method = tahr_pkg::METHOD_PER_SENSOR;
    apply_config(cfg);
    send_item(check_item(-2048, 2047, 2, 0, 0, 0, 0));

    // random phases, each under a fresh setup
    for (int p = 0; p < RandomPhases; p++) begin
      drain();
      apply_config(random_config());
      // one phase with no idling on either side
      idle_pct  = (p == 1) ? 0 : 20;
      stall_pct <= (p == 1) ? 0 : 20;
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 2 && n == 20) hold_requests <= hold_requests + 1;
        if (p == 2 && n == 70) drain();
        send_item(random_item());
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.awaited_outputs.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
